@@ design/upd_pkg.sv @@
package upd_pkg;

  localparam int CAP_W = 13;
  localparam int LEN_W = 12;
  localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;

  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       end_flag;
    logic [7:0] chr;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_pct;
    logic       is_plus;
  } upd_item_t;

  typedef enum logic [2:0] {
    PH_OUT  = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } upd_phase_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [7:0] d;
    logic [4:0] res;
    begin
      res = 5'd0;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
        d = ch - CHAR_0;
        res = {1'b1, d[3:0]};
      end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
        d = ch - CHAR_UA;
        res = {1'b1, d[3:0] + HEX_ALPHA_OFS};
      end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
        d = ch - CHAR_LA;
        res = {1'b1, d[3:0] + HEX_ALPHA_OFS};
      end
      return res;
    end
  endfunction

endpackage

@@ design/upd_front.sv @@
module upd_front import upd_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end,
  input  logic       q_full,
  output logic       q_push,
  output upd_item_t  q_item
);

  logic [4:0] hex;

  assign hex = hex_decode(in_char);

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_item.end_flag = in_end;
    q_item.chr = in_char;
    q_item.is_hex = hex[4];
    q_item.hex_val = hex[3:0];
    q_item.is_pct = (in_char == CHAR_PCT);
    q_item.is_plus = (in_char == CHAR_PLUS);
  end

endmodule

@@ design/upd_fifo.sv @@
module upd_fifo import upd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  upd_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output upd_item_t head
);

  upd_item_t  mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/upd_back.sv @@
module upd_back import upd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             q_empty,
  input  upd_item_t        q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic             out_ok,
  output logic [LEN_W-1:0] out_length
);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] eff_cap;

  upd_phase_t       phase_r;
  upd_phase_t       phase_nxt;
  logic [3:0]       high_r;
  logic [3:0]       high_nxt;
  logic [CAP_W-1:0] count_r;
  logic [CAP_W-1:0] count_nxt;
  logic [CAP_W-1:0] count_inc;
  logic             err_r;
  logic             err_nxt;
  logic             seen_r;
  logic             seen_nxt;

  logic             emit;
  logic             emit_kind;
  logic [7:0]       emit_byte;
  logic             emit_ok;
  logic [LEN_W-1:0] emit_len;
  logic             data_emit;
  logic [7:0]       data_byte;

  logic             ov_r;
  logic             ov_nxt;
  logic             kind_r;
  logic [7:0]       byte_r;
  logic             ok_r;
  logic [LEN_W-1:0] len_r;

  assign eff_cap = (capacity_r > MAX_CAPACITY) ? MAX_CAPACITY : capacity_r;
  assign count_inc = count_r + 1'b1;
  assign q_pop = !q_empty && (!ov_r || !out_stall);

  always_comb begin
    phase_nxt = phase_r;
    high_nxt = high_r;
    count_nxt = count_r;
    err_nxt = err_r;
    seen_nxt = seen_r;
    emit = 1'b0;
    emit_kind = KIND_DATA;
    emit_byte = 8'd0;
    emit_ok = 1'b0;
    emit_len = '0;
    data_emit = 1'b0;
    data_byte = 8'd0;

    if (q_head.end_flag) begin
      emit = 1'b1;
      emit_kind = KIND_STATUS;
      emit_ok = seen_r && !err_r;
      emit_len = emit_ok ? count_r[LEN_W-1:0] : '0;
      phase_nxt = PH_OUT;
      high_nxt = 4'd0;
      count_nxt = '0;
      err_nxt = 1'b0;
      seen_nxt = 1'b0;
    end else begin
      seen_nxt = 1'b1;
      if (err_r) begin
        err_nxt = 1'b1;
      end else if (count_r >= eff_cap) begin
        err_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HIGH: begin
            if (!q_head.is_hex) begin
              err_nxt = 1'b1;
              phase_nxt = PH_OUT;
            end else begin
              high_nxt = q_head.hex_val;
              phase_nxt = PH_LOW;
            end
          end
          PH_LOW: begin
            phase_nxt = PH_OUT;
            if (!q_head.is_hex) begin
              err_nxt = 1'b1;
            end else begin
              data_emit = 1'b1;
              data_byte = {high_r, q_head.hex_val};
            end
          end
          default: begin
            if (q_head.is_pct) begin
              phase_nxt = PH_HIGH;
            end else begin
              data_emit = 1'b1;
              data_byte = q_head.is_plus ? CHAR_SPACE : q_head.chr;
            end
          end
        endcase
        if (data_emit) begin
          emit = 1'b1;
          emit_byte = data_byte;
          count_nxt = count_inc;
          if (count_inc >= eff_cap) begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r && out_stall;
    if (q_pop && emit) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      phase_r <= PH_OUT;
      high_r <= 4'd0;
      count_r <= '0;
      err_r <= 1'b0;
      seen_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_data;
      end
      if (q_pop) begin
        phase_r <= phase_nxt;
        high_r <= high_nxt;
        count_r <= count_nxt;
        err_r <= err_nxt;
        seen_r <= seen_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      kind_r <= emit_kind;
      byte_r <= emit_byte;
      ok_r <= emit_ok;
      len_r <= emit_len;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_byte = byte_r;
  assign out_ok = ok_r;
  assign out_length = len_r;

endmodule

@@ design/url_percent_decoder.sv @@
// Percent decoder for URL-encoded strings, one character per input beat.
// The input channel carries in_char and in_end; a beat with in_end high
// terminates the string. The output channel carries either a decoded data
// byte (out_kind low) or the final status of the string (out_kind high)
// with out_ok and out_length. Character beats that open or continue an
// escape, or arrive after an error, produce no output beat.
// The capacity register is written through cfg_we and cfg_data while the
// block is idle (a user rule the block does not enforce) and applies to
// the following beats. An accepted beat is written into a two-entry queue;
// the back end pops it once the output register is free or being taken,
// and that edge also loads the beat's result into the output register.
// The block sustains one beat per cycle while the receiver does not stall;
// the decode state held by the back end is the only loop.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_stall rises once both queue entries are occupied.
// Synchronous reset empties the queue and output register, clears the
// per-string state and sets the capacity to 4096.
module url_percent_decoder import upd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char,
  input  logic             in_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic             out_ok,
  output logic [LEN_W-1:0] out_length
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  upd_item_t q_item;
  upd_item_t q_head;

  upd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .in_end   (in_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  upd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_ok     (out_ok),
    .out_length (out_length)
  );

endmodule

@@ sim/url_percent_decoder_test.sv @@
`timescale 1ns / 100ps

module url_percent_decoder_test;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BEATS = 1030;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic             ok;
    logic [LEN_W-1:0] length;
  } result_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         given;
    result_t    want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_char;
  logic             in_end;
  logic             out_valid;
  logic             out_stall;
  logic             out_kind;
  logic [7:0]       out_byte;
  logic             out_ok;
  logic [LEN_W-1:0] out_length;

  logic [CAP_W-1:0] capacity_reg;
  upd_phase_t       esc_phase;
  logic [3:0]       high_nib;
  logic [CAP_W-1:0] byte_count;
  bit               string_failed;
  bit               string_started;

  result_t   expected_results[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        beats_sent;
  int        hold_cycles;
  bit        steady;

  url_percent_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .in_end     (in_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_ok     (out_ok),
    .out_length (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= CHAR_0 && ch <= CHAR_9) return int'(ch - CHAR_0);
    if (ch >= CHAR_UA && ch <= CHAR_UF) return int'(ch - CHAR_UA) + 10;
    if (ch >= CHAR_LA && ch <= CHAR_LF) return int'(ch - CHAR_LA) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] random_non_hex_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (hex_nibble(ch) >= 0);
    return ch;
  endfunction

  function automatic result_t data_beat(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.data = b;
    return r;
  endfunction

  function automatic result_t status_beat(input logic ok, input logic [LEN_W-1:0] len);
    result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.ok = ok;
    r.length = len;
    return r;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic last,
                                      output bit has, output result_t r);
    logic [CAP_W-1:0] limit;
    int nib;
    has = 1'b0;
    r = '0;
    limit = (capacity_reg > MAX_CAPACITY) ? MAX_CAPACITY : capacity_reg;
    nib = hex_nibble(ch);
    if (last) begin
      has = 1'b1;
      r.kind = KIND_STATUS;
      if (string_started && !string_failed) begin
        r.ok = 1'b1;
        r.length = byte_count[LEN_W-1:0];
      end
      esc_phase = PH_OUT;
      high_nib = '0;
      byte_count = '0;
      string_failed = 1'b0;
      string_started = 1'b0;
    end else begin
      string_started = 1'b1;
      if (!string_failed) begin
        if (byte_count >= limit) begin
          string_failed = 1'b1;
        end else if (esc_phase == PH_HIGH) begin
          if (nib < 0) begin
            string_failed = 1'b1;
            esc_phase = PH_OUT;
          end else begin
            high_nib = nib[3:0];
            esc_phase = PH_LOW;
          end
        end else if (esc_phase == PH_LOW) begin
          esc_phase = PH_OUT;
          if (nib < 0) begin
            string_failed = 1'b1;
          end else begin
            has = 1'b1;
            r.data = {high_nib, nib[3:0]};
          end
        end else if (ch == CHAR_PCT) begin
          esc_phase = PH_HIGH;
        end else begin
          has = 1'b1;
          r.data = (ch == CHAR_PLUS) ? CHAR_SPACE : ch;
        end
        if (has) begin
          r.kind = KIND_DATA;
          byte_count++;
          if (byte_count >= limit) string_failed = 1'b1;
        end
      end
    end
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic last,
                                  input bit given = 1'b0, input result_t want = '0);
    stim_row_t row;
    row.ch = ch;
    row.last = last;
    row.given = given;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic last,
                           input bit given = 1'b0, input result_t want = '0);
    int gap;
    bit has;
    result_t r;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_end <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_char(ch, last, has, r);
    if (given) begin
      expected_results.push_back(want);
    end else if (has) begin
      expected_results.push_back(r);
    end
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic send_random_string();
    int tokens;
    logic [7:0] ch;
    tokens = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    repeat (tokens) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6: begin
          ch = 8'($urandom_range(0, 255));
          if (ch == CHAR_PCT) ch = CHAR_PLUS;
          send_beat(ch, 1'b0);
        end
        7, 8: send_beat(CHAR_PLUS, 1'b0);
        9, 10, 11, 12, 13: begin
          send_beat(CHAR_PCT, 1'b0);
          send_beat(random_hex_char(), 1'b0);
          send_beat(random_hex_char(), 1'b0);
        end
        14: begin
          send_beat(CHAR_PCT, 1'b0);
          if ($urandom_range(0, 1)) begin
            send_beat(random_non_hex_char(), 1'b0);
          end else begin
            send_beat(random_hex_char(), 1'b0);
            send_beat(random_non_hex_char(), 1'b0);
          end
        end
        default: send_beat(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      send_beat(CHAR_PCT, 1'b0);
      if ($urandom_range(0, 1)) send_beat(random_hex_char(), 1'b0);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // A result beat is taken at a rising edge with out_valid high and out_stall low.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected: kind %h byte %h ok %h length %h",
                 $time, out_kind, out_byte, out_ok, out_length);
      end else begin
        want = expected_results.pop_front();
        compare_field("out_kind", 16'(want.kind), 16'(out_kind));
        compare_field("out_byte", 16'(want.data), 16'(out_byte));
        compare_field("out_ok", 16'(want.ok), 16'(out_ok));
        compare_field("out_length", 16'(want.length), 16'(out_length));
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      n = steady ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    int strings;
    logic [CAP_W-1:0] cap;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_char = '0;
    in_end = 1'b0;
    steady = 1'b0;
    hold_cycles = 0;
    errors = 0;
    beats_sent = 0;
    capacity_reg = CAPACITY_RESET;
    esc_phase = PH_OUT;
    high_nib = '0;
    byte_count = '0;
    string_failed = 1'b0;
    string_started = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    add_row("a", 1'b0, 1'b1, data_beat("a"));
    add_row(CHAR_PLUS, 1'b0, 1'b1, data_beat(CHAR_SPACE));
    add_row(8'h00, 1'b0, 1'b1, data_beat(8'h00));
    add_row(8'hFF, 1'b0, 1'b1, data_beat(8'hFF));
    add_row(CHAR_PCT, 1'b0);
    add_row("4", 1'b0);
    add_row("a", 1'b0);
    add_row(CHAR_PCT, 1'b0);
    add_row("F", 1'b0);
    add_row("0", 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, status_beat(1'b1, 12'd6));
    add_row(CHAR_PCT, 1'b0);
    add_row("g", 1'b0);
    add_row("x", 1'b0);
    add_row(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    add_row(CHAR_PCT, 1'b0);
    add_row("4", 1'b0);
    add_row("G", 1'b0);
    add_row(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    add_row("z", 1'b0);
    add_row(CHAR_PCT, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, status_beat(1'b1, 12'd1));
    add_row(CHAR_PCT, 1'b0);
    add_row("4", 1'b0);
    add_row(8'h00, 1'b1, 1'b1, status_beat(1'b1, 12'd0));
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].ch, directed_rows[i].last,
                directed_rows[i].given, directed_rows[i].want);
    end

    set_capacity(13'd1);
    send_beat("a", 1'b0, 1'b1, data_beat("a"));
    send_beat("b", 1'b0);
    send_beat(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    set_capacity('0);
    send_beat("q", 1'b0);
    send_beat(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    // The limit drops to the count already reached within the string.
    set_capacity(13'd3);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    set_capacity(13'd2);
    send_beat("c", 1'b0);
    send_beat(8'h00, 1'b1, 1'b1, status_beat(1'b0, '0));
    set_capacity('1);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    send_beat(8'h00, 1'b1, 1'b1, status_beat(1'b1, 12'd2));

    // The receiver stalls for a long stretch while beats keep coming.
    set_capacity(MAX_CAPACITY);
    steady = 1'b1;
    hold_cycles = 60;
    repeat (6) send_random_string();
    drain_results();
    steady = 1'b0;

    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0: cap = '0;
        1: cap = 13'd1;
        2: cap = 13'd2;
        3: cap = MAX_CAPACITY;
        4: cap = '1;
        5: cap = 13'($urandom_range(4097, 8191));
        default: cap = 13'($urandom_range(3, 24));
      endcase
      set_capacity(cap);
      steady = ($urandom_range(0, 3) == 0);
      strings = $urandom_range(3, 10);
      repeat (strings) send_random_string();
    end

    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
